### src/order_statistic_set_defines.svh
// ----------------------------------------------------------------------------
// order_statistic_set_defines: assertion macros
// Shared concurrent assertion forms for the order statistic set.
// ----------------------------------------------------------------------------
`ifndef ORDER_STATISTIC_SET_DEFINES_SVH
`define ORDER_STATISTIC_SET_DEFINES_SVH

// same-cycle implication
`define OSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/oss_pkg.sv
// ----------------------------------------------------------------------------
// oss_pkg: order statistic set package
// Sizes, request and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package oss_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int RANK_W   = 6;
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 3'd0,
    FN_REMOVE = 3'd1,
    FN_FIND   = 3'd2,
    FN_SELECT = 3'd3,
    FN_RANK   = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_DUP  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic cmp;  // latch compare flags
    logic ins;  // shift up, open slot for new key
    logic rem;  // shift down over removed key
  } cell_ctl_t;

endpackage

`default_nettype wire

### src/oss_cell.sv
// ----------------------------------------------------------------------------
// oss_cell: one slot of the sorted chain
// Holds one key, compares it against the request key and shifts with its
// neighbors on insert and remove.
// ----------------------------------------------------------------------------
`default_nettype none

module oss_cell import oss_pkg::*; (
  input  wire logic                    clk,
  input  wire cell_ctl_t               ctl,
  input  wire logic                    occ,
  input  wire logic signed [KEY_W-1:0] req_key,
  input  wire logic signed [KEY_W-1:0] left_key,
  input  wire logic                    left_lt,
  input  wire logic signed [KEY_W-1:0] right_key,
  output logic signed [KEY_W-1:0]      key,
  output logic                         lt,
  output logic                         eq
);

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      lt <= occ && (key < req_key);
      eq <= occ && (key == req_key);
    end
    if (ctl.ins && !lt) begin
      key <= left_lt ? req_key : left_key;
    end else if (ctl.rem && !lt) begin
      key <= right_key;
    end
  end

endmodule

`default_nettype wire

### src/oss_enc.sv
// ----------------------------------------------------------------------------
// oss_enc: one-hot to index encoder
// Turns the match vector of the chain into a slot index and a hit flag.
// ----------------------------------------------------------------------------
`default_nettype none

module oss_enc import oss_pkg::*; (
  input  wire logic [CAPACITY-1:0] hot,
  output logic [IDX_W-1:0]         idx,
  output logic                     any
);

  always_comb begin
    idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hot[i]) idx = idx | IDX_W'(i);
    end
    any = |hot;
  end

endmodule

`default_nettype wire

### src/order_statistic_set.sv
// ----------------------------------------------------------------------------
// order_statistic_set: bounded ordered set with rank queries
// Sorted chain of key cells; insert, remove, find, select and rank.
// ----------------------------------------------------------------------------
// channel   direction  handshake         fields
// request   in         start / busy      func, key_in, rank_in
// result    out        done (strobe)     status, key_out, rank_out
//
// Every cell compares its key in phase_a; the chain shifts and the result
// register loads in phase_b, which follows it.
// done is high in the cycle after phase_b; a new item may start in it.
// busy is high for the compare cycle only, so a new item may start in phase_b.
// rst is synchronous and empties the set; no clearing pass.
// The receiver cannot stall; done is never held.
// ----------------------------------------------------------------------------
`default_nettype none

module order_statistic_set import oss_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [FUNC_W-1:0]       func,
  input  wire logic signed [KEY_W-1:0] key_in,
  input  wire logic [RANK_W-1:0]       rank_in,
  output logic                         done,
  output logic [STATUS_W-1:0]          status,
  output logic signed [KEY_W-1:0]      key_out,
  output logic [RANK_W-1:0]            rank_out
);

  `include "order_statistic_set_defines.svh"

  logic                    phase_a;
  logic                    phase_b;
  logic [FUNC_W-1:0]       req_func;
  logic signed [KEY_W-1:0] req_key;
  logic [RANK_W-1:0]       req_rank;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;

  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0]     lt_vec;
  logic [CAPACITY-1:0]     eq_vec;
  logic [CAPACITY-1:0]     occ_vec;
  cell_ctl_t               ctl;

  logic [IDX_W-1:0]        hit_idx;
  logic                    present;
  logic                    full;
  logic signed [KEY_W-1:0] sel_key;

  logic [STATUS_W-1:0]     status_next;
  logic signed [KEY_W-1:0] key_out_next;
  logic [RANK_W-1:0]       rank_out_next;

  assign busy = phase_a;
  assign full = (count == CNT_W'(CAPACITY));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_a <= 1'b0;
      phase_b <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      phase_a <= start && !busy;
      phase_b <= phase_a;
      done    <= phase_b;
      count   <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_func <= func;
      req_key  <= key_in;
      req_rank <= rank_in;
    end
    if (phase_b) begin
      status   <= status_next;
      key_out  <= key_out_next;
      rank_out <= rank_out_next;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KEY_W-1:0] left_key;
    logic                    left_lt;
    logic signed [KEY_W-1:0] right_key;

    assign occ_vec[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign left_key = req_key;
      assign left_lt  = 1'b1;
    end else begin : g_mid
      assign left_key = cell_key[i-1];
      assign left_lt  = lt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = cell_key[i];
    end else begin : g_body
      assign right_key = cell_key[i+1];
    end

    oss_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ_vec[i]),
      .req_key   (req_key),
      .left_key  (left_key),
      .left_lt   (left_lt),
      .right_key (right_key),
      .key       (cell_key[i]),
      .lt        (lt_vec[i]),
      .eq        (eq_vec[i])
    );
  end

  oss_enc u_enc (
    .hot (eq_vec),
    .idx (hit_idx),
    .any (present)
  );

  always_comb begin
    sel_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (32'(req_rank) == 32'(i)) sel_key = sel_key | cell_key[i];
    end
  end

  always_comb begin
    ctl.cmp       = phase_a;
    ctl.ins       = 1'b0;
    ctl.rem       = 1'b0;
    count_next    = count;
    status_next   = ST_MISS;
    key_out_next  = '0;
    rank_out_next = '0;
    unique case (req_func)
      FN_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (present) begin
          status_next = ST_DUP;
        end else begin
          status_next = ST_OK;
          ctl.ins     = phase_b;
        end
      end
      FN_REMOVE: begin
        if (present) begin
          status_next = ST_OK;
          ctl.rem     = phase_b;
        end
      end
      FN_FIND: begin
        if (present) begin
          status_next   = ST_OK;
          key_out_next  = req_key;
          rank_out_next = RANK_W'(hit_idx);
        end
      end
      FN_SELECT: begin
        if (32'(req_rank) < 32'(count)) begin
          status_next  = ST_OK;
          key_out_next = sel_key;
        end
      end
      FN_RANK: begin
        if (present) begin
          status_next   = ST_OK;
          rank_out_next = RANK_W'(hit_idx);
        end
      end
      default: begin
        status_next = ST_MISS;
      end
    endcase
    if (ctl.ins) count_next = count + CNT_W'(1);
    if (ctl.rem) count_next = count - CNT_W'(1);
  end

  `OSS_ASSERT_NOW(a_count_cap, 1'b1, count <= CNT_W'(CAPACITY), "count above capacity")
  `OSS_ASSERT_NOW(a_lt_prefix, phase_b, ((lt_vec + 1'b1) & lt_vec) == '0, "chain out of order")
  `OSS_ASSERT_NOW(a_eq_single, phase_b, $onehot0(eq_vec), "key held in two cells")
  `OSS_ASSERT_NEXT(a_ins_count, ctl.ins, count == $past(count) + CNT_W'(1), "insert count slip")

endmodule

`default_nettype wire
